// ===== design/bfv_multiply_relinearize_unit_macros.svh =====
// assertion helpers for the multiply/relinearize unit
`ifndef BFV_MULTIPLY_RELINEARIZE_UNIT_MACROS_SVH
`define BFV_MULTIPLY_RELINEARIZE_UNIT_MACROS_SVH
// implication checked on every clock, quiet in reset
`define BFV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define BFV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/bfv_pkg.sv =====
`timescale 1ns / 1ps
package bfv_pkg;
   localparam int unsigned POLY_DEGREE_DEFAULT = 8;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned HALF_W = 16;
   localparam int unsigned SCALE_SHIFT = 31;
   localparam int unsigned SCALE_MULT_SHIFT = 8;
   localparam logic OP_KEY = 1'b0;
   localparam logic OP_OPERAND = 1'b1;
   // product selected in each tensor multiply cycle
   localparam logic [1:0] PASS_A0B0 = 2'd0;
   localparam logic [1:0] PASS_A0B1 = 2'd1;
   localparam logic [1:0] PASS_A1B0 = 2'd2;
   localparam logic [1:0] PASS_A1B1 = 2'd3;
   // product selected in each relinearize multiply cycle
   localparam logic [1:0] PASS_K00_LO = 2'd0;
   localparam logic [1:0] PASS_K10_HI = 2'd1;
   localparam logic [1:0] PASS_K01_LO = 2'd2;
   localparam logic [1:0] PASS_K11_HI = 2'd3;
   // key polynomial select
   localparam logic [1:0] KEY_00 = 2'd0;
   localparam logic [1:0] KEY_01 = 2'd1;
   localparam logic [1:0] KEY_10 = 2'd2;
   localparam logic [1:0] KEY_11 = 2'd3;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_TRD  = 9'b000000010,
      ST_TMAC = 9'b000000100,
      ST_TDRN = 9'b000001000,
      ST_TWB  = 9'b000010000,
      ST_RRD  = 9'b000100000,
      ST_RMAC = 9'b001000000,
      ST_RDRN = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   function automatic logic [WORD_W-1:0] scale_round(input logic [63:0] d);
      logic [63:0] s;
      logic [32:0] t;
      begin
         s = d + (d << SCALE_MULT_SHIFT);
         t = s[63:SCALE_SHIFT];
         scale_round = t[32:1] + {31'd0, t[0]};
      end
   endfunction
endpackage

// ===== design/bfv_ram.sv =====
`timescale 1ns / 1ps
module bfv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/bfv_multiply_relinearize_unit.sv =====
`timescale 1ns / 1ps
// channel | handshake            | fields
// req_    | req_valid, req_ready | op, key_select, coeff_index, key_word, four ct coeffs, start
// rsp_    | rsp_valid, rsp_ready | out_index, result_c0, result_c1, out_last
// a key or operand transaction without start is taken while idle
// a start transaction keeps req_ready low until the last row leaves ST_OUT, including
// any time a row waits in ST_OUT for the previous result to be taken
// every tensor or relinearize step is one read state and four products on the shared 32x32
// multiplier; every row adds a drain state and a write-back or output state
// reset is synchronous and clears only the sequencer and valid flags; the stores start undefined
module bfv_multiply_relinearize_unit #(
   parameter int unsigned POLY_DEGREE = bfv_pkg::POLY_DEGREE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [1:0]  req_key_select,
   input  logic [2:0]  req_coeff_index,
   input  logic [31:0] req_key_word,
   input  logic [31:0] req_first_ct_c0,
   input  logic [31:0] req_first_ct_c1,
   input  logic [31:0] req_second_ct_c0,
   input  logic [31:0] req_second_ct_c1,
   input  logic        req_start_multiply,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_index,
   output logic [31:0] rsp_result_c0,
   output logic [31:0] rsp_result_c1,
   output logic        rsp_out_last
);
   localparam int unsigned IW = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;
   localparam int unsigned HW = bfv_pkg::HALF_W;

   bfv_pkg::state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]    pass_ff, pass_in;       // product within a step
   logic [63:0]   acc0_ff, acc0_in, acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [31:0]   r0_ff, r0_in, r1_ff, r1_in;
   logic [63:0]   prod_ff, prod_in;
   logic          prod_valid_ff, prod_valid_in;
   logic          prod_relin_ff, prod_relin_in;
   logic [1:0]    prod_pass_ff, prod_pass_in;
   logic          prod_wrap_ff, prod_wrap_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_index_ff, rsp_index_in;
   logic [31:0]   rsp_c0_ff, rsp_c0_in, rsp_c1_ff, rsp_c1_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept, in_range, load_operand, load_key, wrap, store_we;
   logic          last_row, last_col;
   logic [IW-1:0] req_idx, k_idx;
   logic [31:0]   a0_q, a1_q, b0_q, b1_q;
   logic [31:0]   k00_q, k01_q, k10_q, k11_q;
   logic [31:0]   quad_q, lin0_q, lin1_q;
   logic [31:0]   quad_lo, quad_hi, ma, mb, prod_lo;

   assign accept = req_valid && req_ready;
   assign in_range = 32'(req_coeff_index) < POLY_DEGREE;
   assign req_idx = IW'(req_coeff_index);
   // loads only while idle, so no store is read and written in the same cycle
   assign load_operand = accept && (req_op == bfv_pkg::OP_OPERAND) && in_range;
   assign load_key = accept && (req_op == bfv_pkg::OP_KEY) && in_range;

   // negacyclic partner index k = i - j, plus N when j passes i
   assign wrap = j_ff > i_ff;
   assign k_idx = wrap ? IW'(32'(i_ff) + POLY_DEGREE - 32'(j_ff)) : i_ff - j_ff;
   assign last_row = 32'(i_ff) == POLY_DEGREE - 1;
   assign last_col = 32'(j_ff) == POLY_DEGREE - 1;
   assign store_we = state_ff == bfv_pkg::ST_TWB;

   // operand store: one ram per polynomial so one transaction writes all four
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_a0 (
      .clock(clock), .wr_en(load_operand), .wr_addr(req_idx), .wr_data(req_first_ct_c0),
      .rd_addr(j_ff), .rd_data(a0_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_a1 (
      .clock(clock), .wr_en(load_operand), .wr_addr(req_idx), .wr_data(req_first_ct_c1),
      .rd_addr(j_ff), .rd_data(a1_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_b0 (
      .clock(clock), .wr_en(load_operand), .wr_addr(req_idx), .wr_data(req_second_ct_c0),
      .rd_addr(k_idx), .rd_data(b0_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_b1 (
      .clock(clock), .wr_en(load_operand), .wr_addr(req_idx), .wr_data(req_second_ct_c1),
      .rd_addr(k_idx), .rd_data(b1_q));

   // key store: one ram per key polynomial, all read at coefficient j
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_k00 (
      .clock(clock), .wr_en(load_key && req_key_select == bfv_pkg::KEY_00),
      .wr_addr(req_idx), .wr_data(req_key_word), .rd_addr(j_ff), .rd_data(k00_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_k01 (
      .clock(clock), .wr_en(load_key && req_key_select == bfv_pkg::KEY_01),
      .wr_addr(req_idx), .wr_data(req_key_word), .rd_addr(j_ff), .rd_data(k01_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_k10 (
      .clock(clock), .wr_en(load_key && req_key_select == bfv_pkg::KEY_10),
      .wr_addr(req_idx), .wr_data(req_key_word), .rd_addr(j_ff), .rd_data(k10_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_k11 (
      .clock(clock), .wr_en(load_key && req_key_select == bfv_pkg::KEY_11),
      .wr_addr(req_idx), .wr_data(req_key_word), .rd_addr(j_ff), .rd_data(k11_q));

   // scaled tensor terms, written once per row and read only in the relinearize phase
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_quad (
      .clock(clock), .wr_en(store_we), .wr_addr(i_ff),
      .wr_data(bfv_pkg::scale_round(acc2_ff)), .rd_addr(k_idx), .rd_data(quad_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_lin0 (
      .clock(clock), .wr_en(store_we), .wr_addr(i_ff),
      .wr_data(bfv_pkg::scale_round(acc0_ff)), .rd_addr(i_ff), .rd_data(lin0_q));
   bfv_ram #(.WIDTH(32), .DEPTH(POLY_DEGREE)) u_lin1 (
      .clock(clock), .wr_en(store_we), .wr_addr(i_ff),
      .wr_data(bfv_pkg::scale_round(acc1_ff)), .rd_addr(i_ff), .rd_data(lin1_q));

   // quadratic term split into 16-bit halves
   assign quad_lo = {{(32-HW){1'b0}}, quad_q[HW-1:0]};
   assign quad_hi = {{HW{1'b0}}, quad_q[31:HW]};

   // shared multiplier: read data stays valid while the address holds through the passes
   always_comb begin
      ma = a0_q;
      mb = b0_q;
      if (state_ff == bfv_pkg::ST_RMAC) begin
         case (pass_ff)
            bfv_pkg::PASS_K00_LO: begin ma = k00_q; mb = quad_lo; end
            bfv_pkg::PASS_K10_HI: begin ma = k10_q; mb = quad_hi; end
            bfv_pkg::PASS_K01_LO: begin ma = k01_q; mb = quad_lo; end
            default:              begin ma = k11_q; mb = quad_hi; end
         endcase
      end else begin
         case (pass_ff)
            bfv_pkg::PASS_A0B0: begin ma = a0_q; mb = b0_q; end
            bfv_pkg::PASS_A0B1: begin ma = a0_q; mb = b1_q; end
            bfv_pkg::PASS_A1B0: begin ma = a1_q; mb = b0_q; end
            default:            begin ma = a1_q; mb = b1_q; end
         endcase
      end
   end

   assign prod_in = {32'd0, ma} * {32'd0, mb};
   assign prod_lo = prod_ff[31:0];

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      pass_in = pass_ff;
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      r0_in = r0_ff;
      r1_in = r1_ff;
      prod_valid_in = 1'b0;
      prod_relin_in = (state_ff == bfv_pkg::ST_RMAC);
      prod_pass_in = pass_ff;
      prod_wrap_in = wrap;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_c0_in = rsp_c0_ff;
      rsp_c1_in = rsp_c1_ff;
      rsp_last_in = rsp_last_ff;

      // accumulate the product registered in the previous multiply cycle
      if (prod_valid_ff) begin
         if (prod_relin_ff) begin
            if (prod_pass_ff == bfv_pkg::PASS_K00_LO || prod_pass_ff == bfv_pkg::PASS_K10_HI) begin
               r0_in = prod_wrap_ff ? r0_ff - prod_lo : r0_ff + prod_lo;
            end else begin
               r1_in = prod_wrap_ff ? r1_ff - prod_lo : r1_ff + prod_lo;
            end
         end else begin
            case (prod_pass_ff)
               bfv_pkg::PASS_A0B0: acc0_in = prod_wrap_ff ? acc0_ff - prod_ff : acc0_ff + prod_ff;
               bfv_pkg::PASS_A1B1: acc2_in = prod_wrap_ff ? acc2_ff - prod_ff : acc2_ff + prod_ff;
               default:            acc1_in = prod_wrap_ff ? acc1_ff - prod_ff : acc1_ff + prod_ff;
            endcase
         end
      end

      case (state_ff)
         bfv_pkg::ST_IDLE: begin
            if (accept && req_op == bfv_pkg::OP_OPERAND && req_start_multiply) begin
               i_in = '0;
               j_in = '0;
               pass_in = bfv_pkg::PASS_A0B0;
               acc0_in = '0;
               acc1_in = '0;
               acc2_in = '0;
               state_in = bfv_pkg::ST_TRD;
            end
         end
         bfv_pkg::ST_TRD: state_in = bfv_pkg::ST_TMAC;
         bfv_pkg::ST_TMAC: begin
            prod_valid_in = 1'b1;
            if (pass_ff == bfv_pkg::PASS_A1B1) begin
               pass_in = bfv_pkg::PASS_A0B0;
               if (last_col) begin
                  j_in = '0;
                  state_in = bfv_pkg::ST_TDRN;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = bfv_pkg::ST_TRD;
               end
            end else begin
               pass_in = pass_ff + 2'd1;
            end
         end
         // last product of the row lands in the accumulators
         bfv_pkg::ST_TDRN: state_in = bfv_pkg::ST_TWB;
         bfv_pkg::ST_TWB: begin
            // scaled d0, d1 and d2 go to the linear and quadratic stores
            acc0_in = '0;
            acc1_in = '0;
            acc2_in = '0;
            if (last_row) begin
               i_in = '0;
               r0_in = '0;
               r1_in = '0;
               state_in = bfv_pkg::ST_RRD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = bfv_pkg::ST_TRD;
            end
         end
         bfv_pkg::ST_RRD: state_in = bfv_pkg::ST_RMAC;
         bfv_pkg::ST_RMAC: begin
            prod_valid_in = 1'b1;
            if (pass_ff == bfv_pkg::PASS_K11_HI) begin
               pass_in = bfv_pkg::PASS_K00_LO;
               if (last_col) begin
                  j_in = '0;
                  state_in = bfv_pkg::ST_RDRN;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = bfv_pkg::ST_RRD;
               end
            end else begin
               pass_in = pass_ff + 2'd1;
            end
         end
         bfv_pkg::ST_RDRN: state_in = bfv_pkg::ST_OUT;
         bfv_pkg::ST_OUT: begin
            // wait here while the previous result transaction is still pending
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 3'(i_ff);
               rsp_c0_in = lin0_q + r0_ff;
               rsp_c1_in = lin1_q + r1_ff;
               rsp_last_in = last_row;
               r0_in = '0;
               r1_in = '0;
               if (last_row) begin
                  i_in = '0;
                  state_in = bfv_pkg::ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = bfv_pkg::ST_RRD;
               end
            end
         end
         default: state_in = bfv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfv_pkg::ST_IDLE;
         i_ff <= '0;
         j_ff <= '0;
         pass_ff <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         pass_ff <= pass_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, qualified by the sequencer
   always_ff @(posedge clock) begin
      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      r0_ff <= r0_in;
      r1_ff <= r1_in;
      prod_ff <= prod_in;
      prod_relin_ff <= prod_relin_in;
      prod_pass_ff <= prod_pass_in;
      prod_wrap_ff <= prod_wrap_in;
      rsp_index_ff <= rsp_index_in;
      rsp_c0_ff <= rsp_c0_in;
      rsp_c1_ff <= rsp_c1_in;
      rsp_last_ff <= rsp_last_in;
   end

   // the output register lets a new request in while the final result waits
   assign req_ready = state_ff == bfv_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_result_c0 = rsp_c0_ff;
   assign rsp_result_c1 = rsp_c1_ff;
   assign rsp_out_last = rsp_last_ff;
endmodule

// ===== design/bfv_multiply_relinearize_unit_checker.sv =====
`timescale 1ns / 1ps
`include "bfv_multiply_relinearize_unit_macros.svh"
module bfv_multiply_relinearize_unit_checker (
   input logic clock, input logic reset,
   input logic req_valid, input logic req_ready,
   input logic rsp_valid, input logic rsp_ready,
   input logic rsp_out_last
);
   `BFV_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BFV_ASSERT_NXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid)
   `BFV_ASSERT_NXT(a_last_idle, clock, reset, rsp_valid && rsp_ready && rsp_out_last, !rsp_valid)
endmodule
bind bfv_multiply_relinearize_unit bfv_multiply_relinearize_unit_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_last(rsp_out_last));

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   localparam int N = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = bfv_pkg::OP_KEY;
   logic [1:0]  req_key_select = '0;
   logic [2:0]  req_coeff_index = '0;
   logic [31:0] req_key_word = '0;
   logic [31:0] req_first_ct_c0 = '0;
   logic [31:0] req_first_ct_c1 = '0;
   logic [31:0] req_second_ct_c0 = '0;
   logic [31:0] req_second_ct_c1 = '0;
   logic        req_start_multiply = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_out_index;
   logic [31:0] rsp_result_c0;
   logic [31:0] rsp_result_c1;
   logic        rsp_out_last;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] c0;
      logic [31:0] c1;
      logic        last;
   } product_coeff_type;

   // predictor copies of the stores
   logic [31:0] key_mem [4*N];
   logic [31:0] opnd_mem [4*N];
   product_coeff_type product_queue [$];
   int mismatch_count = 0;
   int burst_left = 0;
   bit stall_free = 1'b0;

   bfv_multiply_relinearize_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // generous cap covering every product plus receiver stalls
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [31:0] scale_product(input logic [63:0] d);
      logic [63:0] s;
      logic [32:0] t;
      begin
         s = d + (d << 8);
         t = s[63:31];
         return t[32:1] + {31'd0, t[0]};
      end
   endfunction

   // negacyclic tensor products, scale, split quadratic term and relinearize
   task automatic predict_product();
      logic [63:0] d0, d1, d2, p0, p1, p2;
      logic [31:0] lin0 [N];
      logic [31:0] lin1 [N];
      logic [31:0] quad [N];
      logic [31:0] r0, r1, lo, hi, s0, s1;
      int k;
      product_coeff_type pc;
      for (int i = 0; i < N; i++) begin
         d0 = 0; d1 = 0; d2 = 0;
         for (int j = 0; j < N; j++) begin
            k = (j > i) ? i + N - j : i - j;
            p0 = 64'(opnd_mem[j]) * 64'(opnd_mem[2*N+k]);
            p1 = 64'(opnd_mem[j]) * 64'(opnd_mem[3*N+k])
               + 64'(opnd_mem[N+j]) * 64'(opnd_mem[2*N+k]);
            p2 = 64'(opnd_mem[N+j]) * 64'(opnd_mem[3*N+k]);
            if (j > i) begin
               d0 -= p0; d1 -= p1; d2 -= p2;
            end else begin
               d0 += p0; d1 += p1; d2 += p2;
            end
         end
         lin0[i] = scale_product(d0);
         lin1[i] = scale_product(d1);
         quad[i] = scale_product(d2);
      end
      for (int i = 0; i < N; i++) begin
         r0 = 0; r1 = 0;
         for (int j = 0; j < N; j++) begin
            k = (j > i) ? i + N - j : i - j;
            lo = quad[k] & 32'hffff;
            hi = quad[k] >> 16;
            s0 = key_mem[j] * lo + key_mem[2*N+j] * hi;
            s1 = key_mem[N+j] * lo + key_mem[3*N+j] * hi;
            if (j > i) begin
               r0 -= s0; r1 -= s1;
            end else begin
               r0 += s0; r1 += s1;
            end
         end
         pc.index = 3'(i);
         pc.c0 = lin0[i] + r0;
         pc.c1 = lin1[i] + r1;
         pc.last = (i == N - 1);
         product_queue.push_back(pc);
      end
   endtask

   // one transaction with a random gap between bursts
   task automatic send_item(input logic op, input logic [1:0] sel, input logic [2:0] idx,
                            input logic [31:0] kw, input logic [31:0] a0,
                            input logic [31:0] a1, input logic [31:0] b0,
                            input logic [31:0] b1, input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_key_select <= sel;
      req_coeff_index <= idx;
      req_key_word <= kw;
      req_first_ct_c0 <= a0;
      req_first_ct_c1 <= a1;
      req_second_ct_c0 <= b0;
      req_second_ct_c1 <= b1;
      req_start_multiply <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // predictor update on acceptance
      if (op == bfv_pkg::OP_KEY) begin
         key_mem[sel*N + idx] = kw;
      end else begin
         opnd_mem[idx] = a0;
         opnd_mem[N+idx] = a1;
         opnd_mem[2*N+idx] = b0;
         opnd_mem[3*N+idx] = b1;
         if (start) predict_product();
      end
      @(negedge clock);
   endtask

   task automatic load_keys(input int mode);
      logic [31:0] w;
      for (int s = 0; s < 4; s++) begin
         for (int i = 0; i < N; i++) begin
            case (mode)
               0: w = '0;
               1: w = '1;
               default: w = $urandom;
            endcase
            send_item(bfv_pkg::OP_KEY, 2'(s), 3'(i), w, $urandom, $urandom, $urandom,
                      $urandom, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // full operand set in random order, start on the last item or on the last reload
   task automatic multiply_set(input int mode, input int extra);
      logic [31:0] v [4];
      int order [N];
      for (int i = 0; i < N; i++) order[i] = i;
      order.shuffle();
      for (int n = 0; n < N; n++) begin
         for (int c = 0; c < 4; c++) begin
            case (mode)
               0: v[c] = '0;
               1: v[c] = '1;
               2: v[c] = 32'h8000_0000 >> $urandom_range(0, 31);
               default: v[c] = $urandom;
            endcase
         end
         send_item(bfv_pkg::OP_OPERAND, 2'($urandom), 3'(order[n]), $urandom, v[0], v[1],
                   v[2], v[3], (n == N - 1 && extra == 0));
      end
      // reloads of some indices, the last of which is the start transaction
      for (int e = 0; e < extra; e++) begin
         send_item(bfv_pkg::OP_OPERAND, 2'($urandom), 3'($urandom), $urandom, $urandom,
                   $urandom, $urandom, $urandom, (e == extra - 1));
      end
   endtask

   task automatic test_extremes();
      load_keys(0);
      multiply_set(1, 0);
      load_keys(1);
      multiply_set(1, 0);
      multiply_set(0, 0);
      multiply_set(2, 0);
   endtask

   task automatic test_random_keys();
      load_keys(2);
      multiply_set(3, 0);
      multiply_set(3, 3);
   endtask

   task automatic test_random_mix();
      int sent;
      sent = 0;
      while (sent < 330) begin
         if ($urandom_range(0, 3) == 0) begin
            // a few rewritten key words between products
            repeat ($urandom_range(1, 6)) begin
               send_item(bfv_pkg::OP_KEY, 2'($urandom), 3'($urandom), $urandom, $urandom,
                         $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         multiply_set($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3,
                      $urandom_range(0, 2));
         sent += N + 2;
      end
   endtask

   // receiver stall pattern with stall-free stretches
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_free <= ~stall_free;
      rsp_ready <= stall_free ? 1'b1 : ($urandom_range(0, 2) != 0);
   end

   // result checker
   always @(posedge clock) begin
      product_coeff_type exp_pc;
      if (!reset && rsp_valid && rsp_ready) begin
         if (product_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transaction");
         end else begin
            exp_pc = product_queue.pop_front();
            if (exp_pc.index !== rsp_out_index || exp_pc.c0 !== rsp_result_c0
                  || exp_pc.c1 !== rsp_result_c1 || exp_pc.last !== rsp_out_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected idx %0d c0 %h c1 %h last %0d, got %0d %h %h %0d",
                     exp_pc.index, exp_pc.c0, exp_pc.c1, exp_pc.last, rsp_out_index,
                     rsp_result_c0, rsp_result_c1, rsp_out_last);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_random_keys();
      test_random_mix();
      req_valid <= 1'b0;
      while (product_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && product_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
